[hdl/dmcmc_pkg.sv]
// ----------------------------------------------------------------------------
// dmcmc_pkg
// Shared types, constants and helpers for the direct-mapped cache miss
// classifier: geometry, register indexes, outcome codes, control bundles.
// ----------------------------------------------------------------------------
package dmcmc_pkg;

    localparam int MAX_SETS = 1024;
    localparam int SET_W    = $clog2(MAX_SETS);
    // largest k with 2^k <= MAX_SETS
    localparam int IDX_LIM  = $clog2(MAX_SETS + 1) - 1;
    localparam int VE_W     = SET_W + 1;

    localparam int ADDR_W   = 32;
    localparam int TAG_W    = 32;
    localparam int CNT_W    = 32;
    localparam int OFS_W    = 5;
    localparam int IB_W     = 4;
    localparam int SHAMT_W  = 6;
    localparam int CFG_W    = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [OFS_W-1:0] OFFSET_BITS_RST = OFS_W'(2);
    localparam logic [IB_W-1:0]  INDEX_BITS_RST  = IB_W'(10);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OFFSET_BITS = 1'b0,
        REG_INDEX_BITS  = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        OUT_HIT        = 2'd0,
        OUT_COMPULSORY = 2'd1,
        OUT_CONFLICT   = 2'd2,
        OUT_CAPACITY   = 2'd3
    } outcome_t;

    typedef enum logic [1:0] {
        ST_CLEAR  = 2'd0,
        ST_IDLE   = 2'd1,
        ST_LOOKUP = 2'd2,
        ST_EVAL   = 2'd3
    } ctrl_state_t;

    typedef struct packed {
        logic clr_step;  // clear one store entry
        logic load;      // capture the incoming address
        logic lookup;    // decode address and read the store
        logic commit;    // classify, update store and counters
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;  // clearing pass is at its final entry
    } dp_stat_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

endpackage

[hdl/direct_mapped_cache_miss_classifier_top.sv]
// ----------------------------------------------------------------------------
// direct_mapped_cache_miss_classifier_top
// Direct-mapped cache lookup with hit / compulsory / conflict / capacity
// classification and saturating event counters.
//
//   channel  direction  handshake            payload
//   input    in         in_valid / in_stall  address
//   result   out        out_valid / out_stall outcome, five counters
//   config   in         cfg_we               cfg_index, cfg_data
//
// An accepted address is captured, then the store is read into a register,
// then the transaction is classified and written back, which also loads the
// result register. A new transaction is taken only after the previous one
// has been classified.
// After reset a clearing pass resets the valid bits of all 1024 entries; input
// stays stalled during it.
// A pending result held by out_stall does not block capture of the next
// address; classification waits until the result register is free.
// ----------------------------------------------------------------------------
module direct_mapped_cache_miss_classifier_top
    import dmcmc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [ADDR_W-1:0]    address,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           outcome,
    output logic [CNT_W-1:0]     access_count,
    output logic [CNT_W-1:0]     hit_count,
    output logic [CNT_W-1:0]     compulsory_count,
    output logic [CNT_W-1:0]     conflict_count,
    output logic [CNT_W-1:0]     capacity_count
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    dmcmc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    dmcmc_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .address          (address),
        .cmd              (cmd),
        .stat             (stat),
        .outcome          (outcome),
        .access_count     (access_count),
        .hit_count        (hit_count),
        .compulsory_count (compulsory_count),
        .conflict_count   (conflict_count),
        .capacity_count   (capacity_count)
    );

endmodule

[hdl/dmcmc_ctrl.sv]
// ----------------------------------------------------------------------------
// dmcmc_ctrl
// Controller: clearing pass after reset, then one transaction at a time
// through address capture, store lookup and classification.
// ----------------------------------------------------------------------------
module dmcmc_ctrl
    import dmcmc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        slot_free;

    // output register is free, or is being emptied at this edge
    assign slot_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
            end
            ST_EVAL:
            begin
                cmd.commit = slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

[hdl/dmcmc_dp.sv]
// ----------------------------------------------------------------------------
// dmcmc_dp
// Datapath: geometry registers, address split, valid/tag store, miss
// classification and saturating counters.
// ----------------------------------------------------------------------------
module dmcmc_dp
    import dmcmc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic [ADDR_W-1:0]    address,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    output logic [1:0]           outcome,
    output logic [CNT_W-1:0]     access_count,
    output logic [CNT_W-1:0]     hit_count,
    output logic [CNT_W-1:0]     compulsory_count,
    output logic [CNT_W-1:0]     conflict_count,
    output logic [CNT_W-1:0]     capacity_count
);

    logic [OFS_W-1:0]  offset_bits_reg;
    logic [IB_W-1:0]   index_bits_reg;
    logic [SET_W-1:0]  clr_cnt_reg;
    logic [VE_W-1:0]   valid_entries_reg, valid_entries_next;

    logic [ADDR_W-1:0] addr_reg;
    logic [SET_W-1:0]  set_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [VE_W-1:0]   sets_reg;
    logic [TAG_W:0]    rd_reg;

    logic [TAG_W:0]    mem [MAX_SETS];

    logic [CNT_W-1:0]  access_reg, access_next;
    logic [CNT_W-1:0]  hit_reg, hit_next;
    logic [CNT_W-1:0]  comp_reg, comp_next;
    logic [CNT_W-1:0]  confl_reg, confl_next;
    logic [CNT_W-1:0]  capac_reg, capac_next;
    outcome_t          outcome_reg, outcome_next;

    logic [IB_W-1:0]    ib_eff;
    logic [ADDR_W-1:0]  addr_sh;
    logic [SET_W-1:0]   set_mask;
    logic [SET_W-1:0]   set_calc;
    logic [SHAMT_W-1:0] tag_shamt;
    logic [TAG_W-1:0]   tag_calc;
    logic [VE_W-1:0]    sets_calc;

    logic               mem_we;
    logic [SET_W-1:0]   mem_waddr;
    logic [TAG_W:0]     mem_wdata;

    // ---- configuration ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg <= OFFSET_BITS_RST;
            index_bits_reg  <= INDEX_BITS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_OFFSET_BITS: offset_bits_reg <= cfg_data;
                REG_INDEX_BITS:  index_bits_reg  <= cfg_data[IB_W-1:0];
                default:         ;
            endcase
        end
    end

    // ---- address split ----
    always_comb
    begin
        ib_eff    = (index_bits_reg > IB_W'(IDX_LIM)) ? IB_W'(IDX_LIM) : index_bits_reg;
        addr_sh   = addr_reg >> offset_bits_reg;
        set_mask  = ~({SET_W{1'b1}} << ib_eff);
        set_calc  = addr_sh[SET_W-1:0] & set_mask;
        tag_shamt = SHAMT_W'(offset_bits_reg) + SHAMT_W'(ib_eff);
        tag_calc  = (tag_shamt >= SHAMT_W'(TAG_W)) ? '0 : (addr_reg >> tag_shamt);
        sets_calc = VE_W'(1) << ib_eff;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            addr_reg <= address;
        if (cmd.lookup)
        begin
            set_reg  <= set_calc;
            tag_reg  <= tag_calc;
            sets_reg <= sets_calc;
        end
    end

    // ---- classification ----
    always_comb
    begin
        if (!rd_reg[TAG_W])
            outcome_next = OUT_COMPULSORY;
        else if (rd_reg[TAG_W-1:0] == tag_reg)
            outcome_next = OUT_HIT;
        else if (valid_entries_reg >= sets_reg)
            outcome_next = OUT_CAPACITY;
        else
            outcome_next = OUT_CONFLICT;
    end

    // ---- valid/tag store ----
    assign mem_we    = cmd.clr_step || (cmd.commit && (outcome_next != OUT_HIT));
    assign mem_waddr = cmd.clr_step ? clr_cnt_reg : set_reg;
    assign mem_wdata = cmd.clr_step ? '0 : {1'b1, tag_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (cmd.lookup)
            rd_reg <= mem[set_calc];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (cmd.clr_step)
            clr_cnt_reg <= clr_cnt_reg + SET_W'(1);
    end

    assign stat.clr_last = (clr_cnt_reg == SET_W'(MAX_SETS - 1));

    // ---- counters ----
    always_comb
    begin
        access_next        = access_reg;
        hit_next           = hit_reg;
        comp_next          = comp_reg;
        confl_next         = confl_reg;
        capac_next         = capac_reg;
        valid_entries_next = valid_entries_reg;
        if (cmd.commit)
        begin
            access_next = sat_inc(access_reg);
            case (outcome_next)
                OUT_HIT:        hit_next = sat_inc(hit_reg);
                OUT_COMPULSORY:
                begin
                    comp_next          = sat_inc(comp_reg);
                    valid_entries_next = valid_entries_reg + VE_W'(1);
                end
                OUT_CONFLICT:   confl_next = sat_inc(confl_reg);
                OUT_CAPACITY:   capac_next = sat_inc(capac_reg);
                default:        access_next = access_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            access_reg        <= '0;
            hit_reg           <= '0;
            comp_reg          <= '0;
            confl_reg         <= '0;
            capac_reg         <= '0;
            valid_entries_reg <= '0;
            outcome_reg       <= OUT_HIT;
        end
        else
        begin
            access_reg        <= access_next;
            hit_reg           <= hit_next;
            comp_reg          <= comp_next;
            confl_reg         <= confl_next;
            capac_reg         <= capac_next;
            valid_entries_reg <= valid_entries_next;
            if (cmd.commit)
                outcome_reg <= outcome_next;
        end
    end

    // counters only move on commit, so they double as the result payload
    assign outcome          = outcome_reg;
    assign access_count     = access_reg;
    assign hit_count        = hit_reg;
    assign compulsory_count = comp_reg;
    assign conflict_count   = confl_reg;
    assign capacity_count   = capac_reg;

endmodule

[hdl/dmcmc_checker.sv]
// ----------------------------------------------------------------------------
// dmcmc_checker
// Port-level checks for the miss classifier, bound to the top level.
// ----------------------------------------------------------------------------
module dmcmc_checker
    import dmcmc_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [1:0]           outcome,
    input logic [CNT_W-1:0]     access_count,
    input logic [CNT_W-1:0]     hit_count,
    input logic [CNT_W-1:0]     capacity_count
);

    // one transaction in flight: input stalls right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted twice in a row");

    // clearing pass holds off input right after reset
    a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> in_stall)
        else $error("input open during clearing pass");

    // a reported hit or capacity miss has been counted
    a_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((outcome != OUT_HIT) || (hit_count != '0))
                   && ((outcome != OUT_CAPACITY) || (capacity_count != '0))
                   && (access_count != '0))
        else $error("result outcome not reflected in counters");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid && $stable(outcome)
                                     && $stable(access_count))
        else $error("stalled result changed");

endmodule

bind direct_mapped_cache_miss_classifier_top dmcmc_checker u_dmcmc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .outcome        (outcome),
    .access_count   (access_count),
    .hit_count      (hit_count),
    .capacity_count (capacity_count)
);

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the direct-mapped cache miss classifier. A short
// stimulus table runs first, with hand-read outcomes on the typed rows.
// Random phases follow, each able to change the cache geometry, built from hot sets
// and a small pool of tags. Every result is checked against an in-bench cache
// model that classifies each accepted address.
// ----------------------------------------------------------------------------
module tb;
    import dmcmc_pkg::*;

    typedef enum logic [1:0] {
        ROW_ACCESS     = 2'd0,
        ROW_SET_OFFSET = 2'd1,
        ROW_SET_INDEX  = 2'd2
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [31:0] value;
        logic        typed;
        outcome_t    want;
    } stim_row_t;

    typedef struct packed {
        outcome_t         outcome;
        logic [CNT_W-1:0] accesses;
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] compulsory;
        logic [CNT_W-1:0] conflicts;
        logic [CNT_W-1:0] capacity;
    } lookup_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [ADDR_W-1:0]    address;
    logic                 out_valid;
    logic                 out_stall;
    logic [1:0]           outcome;
    logic [CNT_W-1:0]     access_count;
    logic [CNT_W-1:0]     hit_count;
    logic [CNT_W-1:0]     compulsory_count;
    logic [CNT_W-1:0]     conflict_count;
    logic [CNT_W-1:0]     capacity_count;

    // cache model state
    logic [OFS_W-1:0]  offset_cfg;
    logic [IB_W-1:0]   index_cfg;
    logic              line_valid [MAX_SETS];
    logic [TAG_W-1:0]  line_tag [MAX_SETS];
    int                filled_lines;
    logic [CNT_W-1:0]  total_accesses;
    logic [CNT_W-1:0]  total_hits;
    logic [CNT_W-1:0]  total_compulsory;
    logic [CNT_W-1:0]  total_conflicts;
    logic [CNT_W-1:0]  total_capacity;

    lookup_result_t    pending_lookups [$];
    stim_row_t         directed_rows [$];
    int                mismatches;
    int                burst_left;
    logic [31:0]       tag_pool [4];
    logic [31:0]       hot_seed [8];

    direct_mapped_cache_miss_classifier_top DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .address          (address),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .outcome          (outcome),
        .access_count     (access_count),
        .hit_count        (hit_count),
        .compulsory_count (compulsory_count),
        .conflict_count   (conflict_count),
        .capacity_count   (capacity_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [CNT_W-1:0] sat_bump(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    // index width actually in use: clamp to what the store can hold
    function automatic int unsigned used_index_bits();
        return (index_cfg > IDX_LIM) ? IDX_LIM : index_cfg;
    endfunction

    function automatic lookup_result_t classify_access(input logic [31:0] addr);
        int unsigned    ib;
        int unsigned    shift;
        int unsigned    set_no;
        logic [63:0]    sets;
        logic [63:0]    tag;
        lookup_result_t r;
        ib     = used_index_bits();
        sets   = 64'd1 << ib;
        set_no = int'(({32'd0, addr} >> offset_cfg) & (sets - 64'd1));
        shift  = offset_cfg + ib;
        tag    = (shift >= 32) ? 64'd0 : ({32'd0, addr} >> shift);
        total_accesses = sat_bump(total_accesses);
        if (!line_valid[set_no])
        begin
            r.outcome          = OUT_COMPULSORY;
            total_compulsory   = sat_bump(total_compulsory);
            line_valid[set_no] = 1'b1;
            line_tag[set_no]   = tag[31:0];
            filled_lines++;
        end
        else if (line_tag[set_no] == tag[31:0])
        begin
            r.outcome  = OUT_HIT;
            total_hits = sat_bump(total_hits);
        end
        else
        begin
            // valid lines outside the current geometry still count toward full
            if (64'(filled_lines) >= sets)
            begin
                r.outcome      = OUT_CAPACITY;
                total_capacity = sat_bump(total_capacity);
            end
            else
            begin
                r.outcome       = OUT_CONFLICT;
                total_conflicts = sat_bump(total_conflicts);
            end
            line_tag[set_no] = tag[31:0];
        end
        r.accesses   = total_accesses;
        r.hits       = total_hits;
        r.compulsory = total_compulsory;
        r.conflicts  = total_conflicts;
        r.capacity   = total_capacity;
        return r;
    endfunction

    // hot sets and a few tags per phase so hits and evictions both happen
    function automatic logic [31:0] make_address();
        int unsigned ib;
        int unsigned pick;
        logic [63:0] sets;
        logic [63:0] set_no;
        logic [63:0] tag;
        logic [63:0] a;
        ib   = used_index_bits();
        sets = 64'd1 << ib;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            return $urandom();
        if (pick < 80)
            set_no = 64'(hot_seed[$urandom_range(0, 7)]) % sets;
        else
            set_no = 64'($urandom()) % sets;
        if (pick < 50)
            tag = 64'(tag_pool[$urandom_range(0, 1)]);
        else if (pick < 90)
            tag = 64'(tag_pool[$urandom_range(0, 3)]);
        else
            tag = 64'($urandom());
        a = (tag << (offset_cfg + ib)) | (set_no << offset_cfg)
            | (64'($urandom()) & ((64'd1 << offset_cfg) - 64'd1));
        return a[31:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic issue_access(input logic [31:0] addr, input logic typed,
                                input outcome_t want);
        lookup_result_t r;
        in_valid <= 1'b1;
        address  <= addr;
        do @(posedge clk); while (in_stall !== 1'b0);
        r = classify_access(addr);
        if (typed)
            r.outcome = want;
        pending_lookups.push_back(r);
        burst_left--;
        if (burst_left <= 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // hold the sender off until every outstanding transaction has returned
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_lookups.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input cfg_reg_t r, input logic [CFG_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (r == REG_OFFSET_BITS)
            offset_cfg = v;
        else
            index_cfg = v[IB_W-1:0];
        @(posedge clk);
    endtask

    initial
    begin : stall_gen
        int   mode;
        int   run;
        int   hold;
        logic level;
        out_stall <= 1'b0;
        mode  = 0;
        run   = 0;
        hold  = 0;
        level = 1'b0;
        forever
        begin
            @(posedge clk);
            if (run == 0)
            begin
                mode = $urandom_range(0, 3);
                run  = $urandom_range(20, 200);
            end
            run--;
            case (mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 3) != 0);
                default:
                begin
                    if (hold == 0)
                    begin
                        level = ~level;
                        hold  = $urandom_range(1, 30);
                    end
                    hold--;
                    out_stall <= level;
                end
            endcase
        end
    end

    always @(posedge clk)
    begin : result_check
        lookup_result_t want;
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            if (pending_lookups.size() == 0)
                report_mismatch("unexpected result outcome", 32'(outcome), 32'd0);
            else
            begin
                want = pending_lookups.pop_front();
                if (outcome !== want.outcome)
                    report_mismatch("outcome", 32'(outcome), 32'(want.outcome));
                if (access_count !== want.accesses)
                    report_mismatch("access_count", access_count, want.accesses);
                if (hit_count !== want.hits)
                    report_mismatch("hit_count", hit_count, want.hits);
                if (compulsory_count !== want.compulsory)
                    report_mismatch("compulsory_count", compulsory_count, want.compulsory);
                if (conflict_count !== want.conflicts)
                    report_mismatch("conflict_count", conflict_count, want.conflicts);
                if (capacity_count !== want.capacity)
                    report_mismatch("capacity_count", capacity_count, want.capacity);
            end
        end
    end

    initial
    begin : stimulus
        int        ph;
        int        n;
        int        k;
        stim_row_t row;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_OFFSET_BITS;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        address   <= '0;
        mismatches       = 0;
        burst_left       = 5;
        offset_cfg       = OFFSET_BITS_RST;
        index_cfg        = INDEX_BITS_RST;
        filled_lines     = 0;
        total_accesses   = '0;
        total_hits       = '0;
        total_compulsory = '0;
        total_conflicts  = '0;
        total_capacity   = '0;
        for (k = 0; k < MAX_SETS; k++)
        begin
            line_valid[k] = 1'b0;
            line_tag[k]   = '0;
        end

        // reset geometry: 4-byte blocks, 1024 sets
        directed_rows.push_back('{ROW_ACCESS, 32'h0000_0000, 1'b1, OUT_COMPULSORY});
        directed_rows.push_back('{ROW_ACCESS, 32'h0000_0000, 1'b1, OUT_HIT});
        directed_rows.push_back('{ROW_ACCESS, 32'hFFFF_FFFF, 1'b1, OUT_COMPULSORY});
        directed_rows.push_back('{ROW_ACCESS, 32'hFFFF_FFFF, 1'b1, OUT_HIT});
        directed_rows.push_back('{ROW_ACCESS, 32'h0000_1000, 1'b0, OUT_HIT});
        directed_rows.push_back('{ROW_ACCESS, 32'h0000_0000, 1'b0, OUT_HIT});
        directed_rows.push_back('{ROW_ACCESS, 32'h0000_0003, 1'b0, OUT_HIT});
        directed_rows.push_back('{ROW_ACCESS, 32'h8000_0000, 1'b0, OUT_HIT});
        // one set, already full: a new tag is a capacity miss
        directed_rows.push_back('{ROW_SET_INDEX, 32'd0, 1'b0, OUT_HIT});
        directed_rows.push_back('{ROW_ACCESS, 32'h0000_0000, 1'b1, OUT_CAPACITY});
        directed_rows.push_back('{ROW_ACCESS, 32'h0000_0000, 1'b1, OUT_HIT});
        // offset past 16 and an index request beyond the store: tag drops to zero
        directed_rows.push_back('{ROW_SET_OFFSET, 32'd31, 1'b0, OUT_HIT});
        directed_rows.push_back('{ROW_SET_INDEX, 32'd15, 1'b0, OUT_HIT});
        directed_rows.push_back('{ROW_ACCESS, 32'h8000_0000, 1'b1, OUT_COMPULSORY});
        directed_rows.push_back('{ROW_ACCESS, 32'h7FFF_FFFF, 1'b1, OUT_HIT});
        directed_rows.push_back('{ROW_SET_OFFSET, 32'd16, 1'b0, OUT_HIT});
        directed_rows.push_back('{ROW_SET_INDEX, 32'd10, 1'b0, OUT_HIT});
        directed_rows.push_back('{ROW_ACCESS, 32'hFFFF_FFFF, 1'b1, OUT_CONFLICT});
        // byte blocks, 8 sets (upper data bit ignored); fill them, then evict
        directed_rows.push_back('{ROW_SET_OFFSET, 32'd0, 1'b0, OUT_HIT});
        directed_rows.push_back('{ROW_SET_INDEX, 32'd19, 1'b0, OUT_HIT});
        directed_rows.push_back('{ROW_ACCESS, 32'h0000_0005, 1'b0, OUT_HIT});
        directed_rows.push_back('{ROW_ACCESS, 32'hFFFF_FFF8, 1'b0, OUT_HIT});
        directed_rows.push_back('{ROW_ACCESS, 32'h0000_0002, 1'b0, OUT_HIT});
        directed_rows.push_back('{ROW_ACCESS, 32'h0000_0003, 1'b0, OUT_HIT});
        directed_rows.push_back('{ROW_ACCESS, 32'h0000_0004, 1'b0, OUT_HIT});
        directed_rows.push_back('{ROW_ACCESS, 32'h0000_0006, 1'b0, OUT_HIT});
        directed_rows.push_back('{ROW_ACCESS, 32'h0000_0007, 1'b0, OUT_HIT});
        directed_rows.push_back('{ROW_ACCESS, 32'h0000_0108, 1'b1, OUT_CAPACITY});

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            case (row.kind)
                ROW_SET_OFFSET:
                begin
                    drain();
                    write_register(REG_OFFSET_BITS, row.value[CFG_W-1:0]);
                end
                ROW_SET_INDEX:
                begin
                    drain();
                    write_register(REG_INDEX_BITS, row.value[CFG_W-1:0]);
                end
                default: issue_access(row.value, row.typed, row.want);
            endcase
        end

        for (ph = 0; ph < 12; ph++)
        begin
            drain();
            if (ph == 0 || $urandom_range(0, 2) != 0)
            begin
                case ($urandom_range(0, 5))
                    0:       write_register(REG_OFFSET_BITS, 5'd0);
                    1:       write_register(REG_OFFSET_BITS, 5'd31);
                    2:       write_register(REG_OFFSET_BITS, 5'($urandom_range(17, 31)));
                    default: write_register(REG_OFFSET_BITS, 5'($urandom_range(0, 8)));
                endcase
            end
            if (ph == 0 || $urandom_range(0, 2) != 0)
            begin
                case ($urandom_range(0, 5))
                    0:       write_register(REG_INDEX_BITS, 5'd10);
                    1:       write_register(REG_INDEX_BITS, 5'($urandom_range(11, 31)));
                    2:       write_register(REG_INDEX_BITS, 5'd0);
                    default: write_register(REG_INDEX_BITS, 5'($urandom_range(1, 6)));
                endcase
            end
            foreach (tag_pool[j])
                tag_pool[j] = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 7)) : $urandom();
            foreach (hot_seed[j])
                hot_seed[j] = $urandom();
            for (n = 0; n < 150; n++)
                issue_access(make_address(), 1'b0, OUT_HIT);
        end

        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending_lookups.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

[filelist.f]
hdl/dmcmc_pkg.sv
hdl/dmcmc_ctrl.sv
hdl/dmcmc_dp.sv
hdl/direct_mapped_cache_miss_classifier_top.sv
hdl/dmcmc_checker.sv
tb/tb.sv
